@@ design/radix_number_formatter_top_macros.svh @@
// Assertion macros shared by the radix formatter RTL
`ifndef RADIX_NUMBER_FORMATTER_TOP_MACROS_SVH
`define RADIX_NUMBER_FORMATTER_TOP_MACROS_SVH

// Checked property, off while reset is asserted
`define RNF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset
`define RNF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rnf_pkg.sv @@
// Types, constants and helper functions for the radix number formatter
package rnf_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned BCD_DIGITS = 10;
    localparam int unsigned BCD_W = 4 * BCD_DIGITS;
    localparam int unsigned WORK_W = 44;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned ITER_W = 5;

    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_ALPHA = 8'd55;
    localparam logic [7:0] CH_MINUS = 8'd45;

    localparam logic [COUNT_W-1:0] HEX_DIGITS = 6'd8;
    localparam logic [COUNT_W-1:0] OCT_DIGITS = 6'd11;
    localparam logic [COUNT_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [COUNT_W-1:0] MAX_BITS = 6'd32;

    typedef enum logic [2:0] {
        CMD_UDEC = 3'd0,
        CMD_SDEC = 3'd1,
        CMD_HEX  = 3'd2,
        CMD_OCT  = 3'd3,
        CMD_BIN  = 3'd4
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    // ASCII for one digit, upper-case letters above nine
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10)
        begin
            ch = CH_ZERO + {4'd0, d};
        end
        else
        begin
            ch = CH_ALPHA + {4'd0, d};
        end
        return ch;
    endfunction

    // Add three to every BCD digit of five or more ahead of the next shift
    function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
            begin
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

endpackage

@@ design/radix_number_formatter_top.sv @@
// Radix number formatter: binary value to ASCII digits, one character per transfer
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_stall       command, value, bit_count
//   out      source     out_valid / out_stall     character, last
//
// Decimal: accept, then the shift-add-3 conversion, then leading-zero skip, then one
// character per cycle (sign included) when not stalled. Hex and octal skip the
// conversion; binary goes straight to emitting bit_count bits (at most 32, none if
// zero). in_stall is high from the accepting edge until the final character is loaded.
// Reset clears sequencer and out_valid; out_stall holds output, sign and emit steps.
`include "radix_number_formatter_top_macros.svh"

module radix_number_formatter_top
    import rnf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [2:0]   command,
    input  logic [31:0]  value,
    input  logic [5:0]   bit_count,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   character,
    output logic         last
);

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 neg_reg, neg_next;
    logic [WORK_W-1:0]    work_reg, work_next;
    logic [VALUE_W-1:0]   src_reg, src_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;

    logic                 in_xfer;
    logic                 out_free;
    logic                 load_out;
    logic [3:0]           top_digit;
    logic [WORK_W-1:0]    work_shift;
    logic [BCD_W-1:0]     bcd_adj;
    logic [BCD_W+VALUE_W-1:0] dabble_shift;
    logic [COUNT_W-1:0]   bin_n;
    logic [COUNT_W-1:0]   bin_shamt;
    logic [VALUE_W-1:0]   bin_aligned;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // Leading digit and digit shift depend on the radix of the item in flight
    always_comb
    begin
        unique case (cmd_reg)
            CMD_OCT:
            begin
                top_digit  = {1'b0, work_reg[WORK_W-1 -: 3]};
                work_shift = work_reg << 3;
            end
            CMD_BIN:
            begin
                top_digit  = {3'd0, work_reg[WORK_W-1]};
                work_shift = work_reg << 1;
            end
            default:
            begin
                top_digit  = work_reg[WORK_W-1 -: 4];
                work_shift = work_reg << 4;
            end
        endcase
    end

    assign bcd_adj      = dabble_adjust(work_reg[WORK_W-1 -: BCD_W]);
    assign dabble_shift = {bcd_adj, src_reg} << 1;

    assign bin_n       = (bit_count > MAX_BITS) ? MAX_BITS : bit_count;
    assign bin_shamt   = MAX_BITS - bin_n;
    assign bin_aligned = value << bin_shamt;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        neg_next   = neg_reg;
        work_next  = work_reg;
        src_next   = src_reg;
        count_next = count_reg;
        iter_next  = iter_reg;
        load_out   = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next  = cmd_t'(command);
                    neg_next  = 1'b0;
                    iter_next = '0;
                    unique case (command)
                        CMD_UDEC:
                        begin
                            src_next   = value;
                            work_next  = '0;
                            state_next = ST_CONV;
                        end
                        CMD_SDEC:
                        begin
                            neg_next   = value[VALUE_W-1];
                            src_next   = value[VALUE_W-1] ? (~value + 32'd1) : value;
                            work_next  = '0;
                            state_next = ST_CONV;
                        end
                        CMD_HEX:
                        begin
                            work_next  = {value, 12'd0};
                            count_next = HEX_DIGITS;
                            state_next = ST_SKIP;
                        end
                        CMD_OCT:
                        begin
                            work_next  = {1'b0, value, 11'd0};
                            count_next = OCT_DIGITS;
                            state_next = ST_SKIP;
                        end
                        CMD_BIN:
                        begin
                            work_next  = {bin_aligned, 12'd0};
                            count_next = bin_n;
                            if (bin_n != '0)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            // unused codes produce nothing
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                work_next = {dabble_shift[BCD_W+VALUE_W-1 -: BCD_W], 4'd0};
                src_next  = dabble_shift[VALUE_W-1:0];
                iter_next = iter_reg + 5'd1;
                if (iter_reg == '1)
                begin
                    count_next = DEC_DIGITS;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if ((count_reg > 6'd1) && (top_digit == 4'd0))
                begin
                    work_next  = work_shift;
                    count_next = count_reg - 6'd1;
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    char_next  = CH_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    char_next  = digit_char(top_digit);
                    last_next  = (count_reg == 6'd1);
                    work_next  = work_shift;
                    count_next = count_reg - 6'd1;
                    if (count_reg == 6'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_UDEC;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        src_reg  <= src_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    `RNF_ASSERT(a_dec_starts_conv,
        (in_xfer && (command == CMD_UDEC || command == CMD_SDEC)) |=> (state_reg == ST_CONV),
        "decimal item did not start conversion")

    `RNF_ASSERT(a_conv_ends_in_skip,
        (state_reg == ST_CONV && iter_reg == '1) |=> (state_reg == ST_SKIP && count_reg == DEC_DIGITS),
        "conversion did not hand over to digit skip")

    `RNF_ASSERT(a_sign_char,
        (state_reg == ST_SIGN && out_free) |=> (out_valid && character == CH_MINUS && !last),
        "minus sign not presented ahead of digits")

    `RNF_ASSERT(a_last_ends_item,
        (state_reg == ST_EMIT && out_free && count_reg == 6'd1) |=>
            (state_reg == ST_IDLE && out_valid && last),
        "final character did not close the item")

    `RNF_ASSERT_ALWAYS(a_count_live,
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> (count_reg != '0),
        "digit count empty while digits pending")

endmodule
